// ----- design/udec_pkg.sv -----
// Shared types, constants and helpers for the lenient UTF-8 decoder.
`default_nettype none

package udec_pkg;

  // Job queue between the byte front end and the decode back end
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam int CPW = 21;

  // Lead byte patterns and payload masks
  localparam logic [7:0] ASCII_LIMIT = 8'h80;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_PAT   = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_PAT   = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_PAT   = 8'hF0;

  localparam logic [CPW-1:0] FOLD_CHAR = 21'h000057;

  // One decode job: up to four bytes, the count used, and the end-of-string mark
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      len;
    logic            fin;
  } job_t;

  // Number of trailing bytes a lead byte asks for; zero when not a lead
  function automatic logic [1:0] follow_len(input logic [7:0] b);
    logic [1:0] k;
    k = 2'd0;
    if ((b & LEAD2_MASK) == LEAD2_PAT) begin
      k = 2'd1;
    end else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
      k = 2'd2;
    end else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
      k = 2'd3;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- design/udec_front.sv -----
// Front end: accepts bytes, gathers multi-byte sequences and issues decode jobs.
`default_nettype none

module udec_front
  import udec_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_byte,
  input  wire logic       is_final,
  input  wire logic       q_full,
  output logic            job_valid,
  output job_t            job
);

  logic [7:0] pend [3];
  logic [1:0] pcount;
  logic [1:0] ncount;
  logic       acc;
  logic [1:0] lead_k;

  assign full   = q_full;
  assign acc    = push && !q_full;
  assign lead_k = follow_len(in_byte);

  // Build the job from the held bytes with the new byte appended
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      job.bytes[i] = (2'(i) < pcount) ? pend[i] : in_byte;
    end
    job.bytes[3] = in_byte;
    job.len      = {1'b0, pcount} + 3'd1;
    job.fin      = is_final;
  end

  // Issue a job on end of string, on a lone byte, or when a sequence completes
  assign job_valid = acc && (is_final ||
                             (pcount == 2'd0 && lead_k == 2'd0) ||
                             (pcount != 2'd0 && ncount <= 2'd1));

  // Track the sequence being gathered
  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= 2'd0;
      ncount <= 2'd0;
    end else if (acc) begin
      if (is_final) begin
        pcount <= 2'd0;
        ncount <= 2'd0;
      end else if (pcount == 2'd0) begin
        if (lead_k != 2'd0) begin
          pcount <= 2'd1;
          ncount <= lead_k;
        end
      end else if (ncount <= 2'd1) begin
        pcount <= 2'd0;
        ncount <= 2'd0;
      end else begin
        pcount <= pcount + 2'd1;
        ncount <= ncount - 2'd1;
      end
    end
  end

  // Hold the lead and trailing bytes
  always_ff @(posedge clk) begin
    if (acc && !is_final) begin
      if (pcount == 2'd0) begin
        if (lead_k != 2'd0) begin
          pend[0] <= in_byte;
        end
      end else if (ncount > 2'd1) begin
        pend[pcount] <= in_byte;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/udec_fifo.sv -----
// Short job queue between the front end and the decode back end.
`default_nettype none

module udec_fifo
  import udec_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire job_t wr_data,
  output logic      full,
  input  wire logic rd_en,
  output job_t      rd_data,
  output logic      empty
);

  job_t               mem [QDEPTH];
  logic [QAW-1:0]     wr_ptr;
  logic [QAW-1:0]     rd_ptr;
  logic [QCW-1:0]     cnt;
  logic               do_wr;
  logic               do_rd;

  assign full    = (cnt == QCW'(QDEPTH));
  assign empty   = (cnt == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + QCW'(1);
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - QCW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) cnt <= QCW'(QDEPTH))
    else $error("job queue occupancy beyond depth");

  assert property (@(posedge clk) disable iff (rst) do_wr |=> !empty)
    else $error("job queue empty right after a write");

endmodule

`default_nettype wire

// ----- design/udec_back.sv -----
// Back end: steps through each job, emitting one code point per cycle when popped.
`default_nettype none

module udec_back
  import udec_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_wr_en,
  input  wire logic           cfg_wr_data,
  input  wire logic           q_empty,
  output logic                q_rd_en,
  input  wire job_t           q_job,
  output logic                empty,
  input  wire logic           pop,
  output logic [CPW-1:0]      code_point,
  output logic                string_done
);

  logic           fold;
  job_t           cur;
  logic           cur_valid;
  logic [1:0]     pos;
  logic           out_valid;
  logic [CPW-1:0] out_code;
  logic           out_done;

  logic           step;
  logic           last;
  logic [7:0]     c1;
  logic [7:0]     c2;
  logic [7:0]     c3;
  logic [7:0]     c4;
  logic [1:0]     k;
  logic           raw;
  logic [2:0]     pos_next;
  logic [CPW-1:0] value;
  logic [CPW-1:0] value_folded;

  // Fold mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      fold <= 1'b0;
    end else if (cfg_wr_en) begin
      fold <= cfg_wr_data;
    end
  end

  // Decode one code point at the current position
  always_comb begin
    c1       = cur.bytes[pos];
    c2       = cur.bytes[pos + 2'd1];
    c3       = cur.bytes[pos + 2'd2];
    c4       = cur.bytes[pos + 2'd3];
    k        = follow_len(c1);
    raw      = (c1 < ASCII_LIMIT) || (k == 2'd0) ||
               (({1'b0, pos} + {1'b0, k}) >= cur.len);
    pos_next = raw ? ({1'b0, pos} + 3'd1) : ({1'b0, pos} + 3'd1 + {1'b0, k});
    value    = CPW'(c1);
    if (!raw) begin
      unique case (k)
        2'd1:    value = CPW'({c1[4:0], c2[5:0]});
        2'd2:    value = CPW'({c1[3:0], c2[5:0], c3[5:0]});
        2'd3:    value = {c1[2:0], c2[5:0], c3[5:0], c4[5:0]};
        default: value = CPW'(c1);
      endcase
    end
    value_folded = (fold && (value[CPW-1:7] != '0)) ? FOLD_CHAR : value;
  end

  assign last    = (pos_next >= cur.len);
  assign step    = cur_valid && (!out_valid || pop);
  assign q_rd_en = !q_empty && (!cur_valid || (step && last));

  // Load and advance the current job
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pos       <= 2'd0;
    end else if (q_rd_en) begin
      cur_valid <= 1'b1;
      pos       <= 2'd0;
    end else if (step) begin
      if (last) begin
        cur_valid <= 1'b0;
      end else begin
        pos <= pos_next[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd_en) begin
      cur <= q_job;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_code <= value_folded;
      out_done <= cur.fin && last;
    end
  end

  assign empty       = !out_valid;
  assign code_point  = out_code;
  assign string_done = out_done;

  assert property (@(posedge clk) disable iff (rst) cur_valid |-> ({1'b0, pos} < cur.len))
    else $error("decode position past end of job");

  assert property (@(posedge clk) disable iff (rst) (out_valid && !pop) |=> out_valid)
    else $error("output word dropped without pop");

endmodule

`default_nettype wire

// ----- design/utf8_lenient_decoder_core.sv -----
// Top level of the lenient UTF-8 decoder: front end, job queue and back end.
`default_nettype none

// Lenient streaming UTF-8 decoder. Bytes enter through push/full and code
// points leave through empty/pop, with one byte accepted and one code point
// delivered per cycle in steady state, while pop is held and the queue has
// room. A lone byte or the byte completing a sequence yields one code
// point; the last byte of a string whose sequence is cut short yields up to
// three, delivered one after another by the back end, which then holds up
// the four-entry job queue and, once that fills, the input. Trailing bytes
// are not checked. fold_non_ascii (cfg_wr_en / cfg_wr_data) replaces code
// points of 128 and above with 'W'; write it only while the block is idle.
module utf8_lenient_decoder_core
  import udec_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           cfg_wr_en,
  input  wire logic           cfg_wr_data,
  input  wire logic           push,
  output logic                full,
  input  wire logic [7:0]     in_byte,
  input  wire logic           is_final,
  output logic                empty,
  input  wire logic           pop,
  output logic [CPW-1:0]      code_point,
  output logic                string_done
);

  job_t wr_job;
  job_t rd_job;
  logic wr_valid;
  logic q_full;
  logic q_empty;
  logic q_rd_en;

  udec_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_byte   (in_byte),
    .is_final  (is_final),
    .q_full    (q_full),
    .job_valid (wr_valid),
    .job       (wr_job)
  );

  udec_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_valid),
    .wr_data (wr_job),
    .full    (q_full),
    .rd_en   (q_rd_en),
    .rd_data (rd_job),
    .empty   (q_empty)
  );

  udec_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_rd_en     (q_rd_en),
    .q_job       (rd_job),
    .empty       (empty),
    .pop         (pop),
    .code_point  (code_point),
    .string_done (string_done)
  );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the lenient UTF-8 decoder core.
module tb_top;
  import udec_pkg::*;

  localparam int          SETTLE_CYCLES   = 8;
  localparam int          STALL_LIMIT     = 1000;
  localparam int          RESET_CYCLES    = 6;
  localparam int unsigned BYTES_PER_PHASE = 30;

  // Top bits of a well-formed continuation byte
  localparam logic [7:0]     TRAIL_PAT      = 8'h80;
  localparam logic [CPW-1:0] CP_ASCII_LIMIT = {{(CPW - 8){1'b0}}, ASCII_LIMIT};

  logic           clk         = 1'b0;
  logic           rst         = 1'b1;
  logic           cfg_wr_en   = 1'b0;
  logic           cfg_wr_data = 1'b0;
  logic           push        = 1'b0;
  logic           full;
  logic [7:0]     in_byte     = 8'h00;
  logic           is_final    = 1'b0;
  logic           empty;
  logic           pop         = 1'b0;
  logic [CPW-1:0] code_point;
  logic           string_done;

  // Idle rates in percent for the byte sender and the word receiver
  int unsigned gap_pct       = 0;
  int unsigned take_idle_pct = 0;
  int unsigned bytes_sent    = 0;
  int unsigned mismatches    = 0;
  int unsigned stall_cycles  = 0;

  // Decoder shadow state and the code points still owed by the block
  logic [7:0]     held [0:2];
  int unsigned    held_cnt    = 0;
  int unsigned    missing_cnt = 0;
  logic           fold_on     = 1'b0;
  logic [CPW-1:0] owed_cp [$];
  logic           owed_done [$];

  utf8_lenient_decoder_core DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .push        (push),
    .full        (full),
    .in_byte     (in_byte),
    .is_final    (is_final),
    .empty       (empty),
    .pop         (pop),
    .code_point  (code_point),
    .string_done (string_done)
  );

  always #4 clk = ~clk;

  // Number of continuation bytes a lead byte gathers; zero for anything else
  function automatic int unsigned trail_count(input logic [7:0] b);
    casez (b)
      8'b110?????: return 1;
      8'b1110????: return 2;
      8'b11110???: return 3;
      default:     return 0;
    endcase
  endfunction

  // Build a code point from a lead at position at and its k continuation bytes
  function automatic logic [CPW-1:0] assemble(input logic [3:0][7:0] seq,
                                              input int unsigned at, input int unsigned k);
    logic [CPW-1:0] v;
    case (k)
      1:       v = {10'd0, seq[at][4:0], seq[at+1][5:0]};
      2:       v = {5'd0, seq[at][3:0], seq[at+1][5:0], seq[at+2][5:0]};
      default: v = {seq[at][2:0], seq[at+1][5:0], seq[at+2][5:0], seq[at+3][5:0]};
    endcase
    return v;
  endfunction

  // Queue one owed word, folded when the mode is on
  function automatic void owe_word(input logic [CPW-1:0] cp, input logic done);
    if (fold_on && cp >= CP_ASCII_LIMIT) begin
      cp = FOLD_CHAR;
    end
    owed_cp.push_back(cp);
    owed_done.push_back(done);
  endfunction

  // Advance the shadow decoder by one accepted byte
  function automatic void predict_byte(input logic [7:0] b, input logic fin);
    logic [3:0][7:0] seq;
    int unsigned     n;
    int unsigned     at;
    int unsigned     k;
    seq = '0;
    n = 0;
    if (fin) begin
      // decode held bytes plus this one as a whole string; open leads go out raw
      for (int i = 0; i < held_cnt; i++) begin
        seq[n] = held[i];
        n++;
      end
      seq[n] = b;
      n++;
      at = 0;
      while (at < n) begin
        k = trail_count(seq[at]);
        if (k == 0 || at + k >= n) begin
          owe_word({{(CPW - 8){1'b0}}, seq[at]}, at + 1 >= n);
          at++;
        end else begin
          owe_word(assemble(seq, at, k), at + k + 1 >= n);
          at += k + 1;
        end
      end
      held_cnt = 0;
      missing_cnt = 0;
    end else if (held_cnt == 0) begin
      k = trail_count(b);
      if (k == 0) begin
        owe_word({{(CPW - 8){1'b0}}, b}, 1'b0);
      end else begin
        held[0] = b;
        held_cnt = 1;
        missing_cnt = k;
      end
    end else if (missing_cnt <= 1) begin
      // last continuation byte closes the sequence
      for (int i = 0; i < held_cnt; i++) begin
        seq[i] = held[i];
      end
      seq[held_cnt] = b;
      owe_word(assemble(seq, 0, trail_count(seq[0])), 1'b0);
      held_cnt = 0;
      missing_cnt = 0;
    end else begin
      held[held_cnt] = b;
      held_cnt++;
      missing_cnt--;
    end
  endfunction

  // Compare one accepted word against the oldest owed one
  function automatic void check_word();
    logic [CPW-1:0] cp_want;
    logic           done_want;
    if (owed_cp.size() == 0) begin
      mismatches++;
      $display("%0t: code_point expected none actual %h (string_done %b)",
               $time, code_point, string_done);
    end else begin
      cp_want = owed_cp.pop_front();
      done_want = owed_done.pop_front();
      if (code_point !== cp_want) begin
        mismatches++;
        $display("%0t: code_point expected %h actual %h", $time, cp_want, code_point);
      end
      if (string_done !== done_want) begin
        mismatches++;
        $display("%0t: string_done expected %b actual %b", $time, done_want, string_done);
      end
    end
  endfunction

  // Track register writes, accepted bytes and accepted words
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_wr_en) begin
        fold_on = cfg_wr_data;
      end
      if (push && !full) begin
        predict_byte(in_byte, is_final);
      end
      if (pop && !empty) begin
        check_word();
      end
    end
  end

  // Drop pop at random at the current receiver idle rate
  always @(posedge clk) begin
    pop <= !rst && ($urandom_range(99, 0) >= take_idle_pct);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Offer one byte, idling first at the sender rate, and hold until accepted
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99, 0) < gap_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_byte <= b;
    is_final <= fin;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  // Hold the sender until every owed word has come, then let the pipe settle
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (owed_cp.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fold(input logic v);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Lone bytes: ASCII extremes, stray continuations, non-lead high bytes
  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hF8, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  // Complete sequences, unchecked continuation top bits, largest value
  task automatic test_sequences();
    send_byte(8'hC0, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'h3F, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hF7, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b1);
  endtask

  // Strings that end inside a sequence, up to three words from one byte
  task automatic test_truncated_end();
    send_byte(8'hC3, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hE2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  // Fold mode on, then back off
  task automatic test_fold();
    write_fold(1'b1);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hC2, 1'b0);
    send_byte(8'h80, 1'b1);
    write_fold(1'b0);
  endtask

  // One string of mostly well-formed units, some noise, some cut short
  task automatic send_random_string();
    logic [7:0]  line [$];
    int unsigned units;
    int unsigned trail;
    int unsigned cut;
    units = $urandom_range(6, 1);
    repeat (units) begin
      trail = 0;
      case ($urandom_range(9, 0))
        0, 1, 2: line.push_back(8'($urandom_range(127, 0)));
        3, 4: begin
          line.push_back(LEAD2_PAT | 8'($urandom_range(31, 0)));
          trail = 1;
        end
        5, 6: begin
          line.push_back(LEAD3_PAT | 8'($urandom_range(15, 0)));
          trail = 2;
        end
        7, 8: begin
          line.push_back(LEAD4_PAT | 8'($urandom_range(7, 0)));
          trail = 3;
        end
        default: line.push_back(8'($urandom_range(255, 0)));
      endcase
      repeat (trail) begin
        if ($urandom_range(7, 0) == 0) begin
          line.push_back(8'($urandom_range(255, 0)));
        end else begin
          line.push_back(TRAIL_PAT | 8'($urandom_range(63, 0)));
        end
      end
    end
    // cut some strings short so a sequence is left open at the end
    if (line.size() > 1 && $urandom_range(3, 0) == 0) begin
      cut = $urandom_range(line.size() - 1, 1);
      while (line.size() > cut) begin
        line.delete(line.size() - 1);
      end
    end
    foreach (line[i]) begin
      send_byte(line[i], i == line.size() - 1);
    end
  endtask

  task automatic run_random_phase(input int unsigned send_gap, input int unsigned recv_gap);
    int unsigned start;
    write_fold($urandom_range(1, 0) == 1);
    gap_pct = send_gap;
    take_idle_pct = recv_gap;
    start = bytes_sent;
    while (bytes_sent - start < BYTES_PER_PHASE) begin
      send_random_string();
    end
  endtask

  task automatic test_random_streams();
    run_random_phase(16, 77);
    run_random_phase(77, 16);
    run_random_phase(0, 0);
  endtask

  initial begin
    gap_pct = 16;
    take_idle_pct = 77;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_single_bytes();
    test_sequences();
    test_truncated_end();
    test_fold();
    test_random_streams();
    wait_drained();
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
